/* hdl/assert_macros.svh */
// assertion helpers for the checker, sampled on clk and off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/cetc_pkg.sv */
package cetc_pkg;

	// fixed point format of the internal registers
	localparam int FRAC_BITS = 28;
	localparam int INT_BITS  = 24;
	localparam int FX_W      = INT_BITS + FRAC_BITS;
	localparam int FXN       = FX_W + 1;
	localparam int HL        = (FXN + 1) / 2;
	localparam int PW        = 2 * FXN;

	// field and register widths
	localparam int ITER_W    = 10;
	localparam int RAD_W     = 20;
	localparam int CNT_W     = ITER_W + 1;
	localparam int CFG_W     = 20;
	localparam int THR_W     = RAD_W + FRAC_BITS;
	localparam int CMP_W     = (FXN > THR_W) ? FXN : THR_W;
	localparam int DIV_LANES = 4;

	// input conversion from q4.28
	localparam int QL = (FRAC_BITS >= 28) ? FRAC_BITS - 28 : 0;
	localparam int QR = (FRAC_BITS < 28) ? 28 - FRAC_BITS : 0;
	localparam logic [32:0] Q_RND = (33'd1 << QR) >> 1;

	typedef logic signed [FXN-1:0] fx_t;
	typedef logic [FXN-1:0] fxu_t;

	localparam fx_t FX_MAX = {1'b0, {FX_W{1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {FX_W{1'b0}}};

	localparam logic [ITER_W-1:0] MAX_ITER_RST = 10'd200;
	localparam logic [RAD_W-1:0]  RADIUS_RST   = 20'd10000;

	typedef enum logic [0:0] {
		REG_MAX_ITER  = 1'b0,
		REG_RADIUS_SQ = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP1,
		ST_PREP2,
		ST_DIV,
		ST_DIVW,
		ST_ZINIT,
		ST_CHECK,
		ST_MUL,
		ST_MULW,
		ST_UPD,
		ST_DONE
	} state_t;

	// multiply sequence of one iteration, in issue order
	typedef enum logic [3:0] {
		OP_ZRR,
		OP_ZII,
		OP_WRR,
		OP_WII,
		OP_WRI,
		OP_SRTR,
		OP_SITI,
		OP_SRTI,
		OP_SITR
	} op_t;

	function automatic fx_t fx_sat(input logic signed [FXN:0] v);
		if (v[FXN] != v[FXN-1]) begin
			return v[FXN] ? FX_MIN : FX_MAX;
		end
		return v[FXN-1:0];
	endfunction

	function automatic fx_t fx_add(input fx_t a, input fx_t b);
		logic signed [FXN:0] s;
		s = {a[FXN-1], a} + {b[FXN-1], b};
		return fx_sat(s);
	endfunction

	function automatic fx_t fx_sub(input fx_t a, input fx_t b);
		logic signed [FXN:0] s;
		s = {a[FXN-1], a} - {b[FXN-1], b};
		return fx_sat(s);
	endfunction

	function automatic fxu_t fx_mag(input fx_t a);
		return a[FXN-1] ? fxu_t'(-a) : fxu_t'(a);
	endfunction

	// q4.28 to internal format, round half away from zero on a right shift
	function automatic fx_t from_q428(input logic signed [31:0] q);
		logic [32:0] qe;
		logic [32:0] qm;
		logic [32:0] qr;
		fx_t m;
		qe = {q[31], q};
		qm = q[31] ? (33'd0 - qe) : qe;
		qr = (qm + Q_RND) >> QR;
		m = fx_t'(qr);
		if (QR == 0) begin
			return fx_t'(q) <<< QL;
		end
		return q[31] ? -m : m;
	endfunction

endpackage

/* hdl/cetc_mul.sv */
module cetc_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cetc_pkg::fx_t a,
	input  cetc_pkg::fx_t b,
	output logic          done,
	output cetc_pkg::fx_t prod
);
	import cetc_pkg::*;

	localparam logic [2:0] K_LAST_PP = 3'd3;
	localparam logic [2:0] K_ROUND   = 3'd5;
	localparam logic [2:0] K_SIGN    = 3'd6;
	localparam logic [PW-1:0] RND    = PW'(1) << (FRAC_BITS - 1);
	localparam logic [PW-1:0] LIM_P  = (PW'(1) << FX_W) - PW'(1);
	localparam logic [PW-1:0] LIM_N  = PW'(1) << FX_W;

	logic          run_q;
	logic [2:0]    k_q;
	logic          pv_s1;
	logic          done_q;
	logic          neg_q;
	fxu_t          ma_q;
	fxu_t          mb_q;
	fxu_t          mag_q;
	fx_t           prod_q;
	logic [PW-1:0] acc_q;
	logic [2*HL-1:0] pp_s1;
	logic [1:0]    sh_s1;

	logic [HL-1:0] a_part;
	logic [HL-1:0] b_part;
	logic [PW-1:0] pp_shift;
	logic [PW-1:0] rsum;
	logic [PW-1:0] rsh;
	logic [PW-1:0] lim;

	// halves of the magnitudes picked by the partial product index
	always_comb begin
		a_part = k_q[1] ? HL'(ma_q[FXN-1:HL]) : ma_q[HL-1:0];
		b_part = k_q[0] ? HL'(mb_q[FXN-1:HL]) : mb_q[HL-1:0];
	end

	always_comb begin
		unique case (sh_s1)
			2'd0:    pp_shift = PW'(pp_s1);
			2'd1:    pp_shift = PW'(pp_s1) << HL;
			2'd2:    pp_shift = PW'(pp_s1) << (2 * HL);
			default: pp_shift = '0;
		endcase
	end

	always_comb begin
		rsum = acc_q + RND;
		rsh  = rsum >> FRAC_BITS;
		lim  = neg_q ? LIM_N : LIM_P;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			k_q    <= '0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				k_q   <= '0;
				pv_s1 <= 1'b0;
			end else if (run_q) begin
				k_q   <= k_q + 3'd1;
				pv_s1 <= (k_q <= K_LAST_PP);
				if (k_q == K_SIGN) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= fx_mag(a);
			mb_q  <= fx_mag(b);
			neg_q <= a[FXN-1] ^ b[FXN-1];
			acc_q <= '0;
		end else if (run_q) begin
			if (k_q <= K_LAST_PP) begin
				pp_s1 <= a_part * b_part;
				sh_s1 <= 2'(k_q[1]) + 2'(k_q[0]);
			end
			if (pv_s1) begin
				acc_q <= acc_q + pp_shift;
			end
			if (k_q == K_ROUND) begin
				mag_q <= (rsh > lim) ? FXN'(lim) : FXN'(rsh);
			end
			if (k_q == K_SIGN) begin
				prod_q <= neg_q ? -fx_t'(mag_q) : fx_t'(mag_q);
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

/* hdl/cetc_div3.sv */
module cetc_div3 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cetc_pkg::fx_t din [cetc_pkg::DIV_LANES],
	output logic          done,
	output cetc_pkg::fx_t quo [cetc_pkg::DIV_LANES]
);
	import cetc_pkg::*;

	localparam int CH_W   = 14;
	localparam int CH_N   = (FXN + CH_W - 1) / CH_W;
	localparam int DV_W   = CH_W * CH_N;
	localparam int V_W    = CH_W + 2;
	localparam int VM_W   = V_W + 1 + CH_W;
	localparam int STEP_W = $clog2(CH_N);
	// (2^(V_W+1) + 1) / 3, exact quotient by three for any V_W-bit value
	localparam logic [V_W-1:0] RECIP = V_W'((2 ** (V_W + 1) + 1) / 3);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CH_N - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// long division by three in 14-bit digits, digit quotient by reciprocal multiply
	for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
		logic [DV_W-1:0] sh_q;
		logic [1:0]      rem_q;
		logic            neg_q;
		logic [V_W-1:0]  v;
		logic [VM_W-1:0] vm;
		logic [CH_W-1:0] qd;
		logic [V_W-1:0]  q3;
		logic [V_W-1:0]  r;

		always_comb begin
			v  = {rem_q, sh_q[DV_W-1 -: CH_W]};
			vm = VM_W'(v * RECIP);
			qd = vm[V_W+1 +: CH_W];
			q3 = {1'b0, qd, 1'b0} + {2'b00, qd};
			r  = v - q3;
		end

		always_ff @(posedge clk) begin
			if (start) begin
				sh_q  <= DV_W'(fx_mag(din[l]));
				rem_q <= '0;
				neg_q <= din[l][FXN-1];
			end else if (run_q) begin
				sh_q  <= {sh_q[DV_W-CH_W-1:0], qd};
				rem_q <= r[1:0];
			end
		end

		assign quo[l] = neg_q ? -fx_t'(sh_q[FXN-1:0]) : fx_t'(sh_q[FXN-1:0]);
	end

	assign done = done_q;

endmodule

/* hdl/cubic_escape_time_counter.sv */
// cubic escape-time counter
// request channel: start with coord_invalid, x_re, x_im, y_re, y_im (signed q4.28); a request
// is taken on a rising edge with start high and busy low, busy then stays high until the
// result has been shown
// result channel: done is high for exactly one cycle with escape_count on the same cycle;
// the receiver cannot stall it, so it must take the count on that edge
// configuration: cfg_valid/cfg_ready write channel, cfg_index 0 sets max_iterations (10 bit),
// cfg_index 1 sets escape_radius_sq (20 bit); cfg_ready is always high, write only while idle
// sequence: an invalid point answers on the cycle after the request (-1)
// otherwise setup (operand prep, a four-digit divide by three, orbit start),
// then the iterations, the final escape test (only the limit check when the limit ends
// the orbit), and the result
// every full iteration runs nine multiplies in turn on one shared 27x27 partial product
// multiplier, so a new point is taken only once the result of the last has been shown
// reset: arst_n low clears the sequencer and loads max_iterations 200 and
// escape_radius_sq 10000; no other clearing is needed
module cubic_escape_time_counter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                coord_invalid,
	input  logic signed [31:0]                  x_re,
	input  logic signed [31:0]                  x_im,
	input  logic signed [31:0]                  y_re,
	input  logic signed [31:0]                  y_im,
	output logic                                done,
	output logic signed [cetc_pkg::CNT_W-1:0]   escape_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [0:0]                          cfg_index,
	input  logic [cetc_pkg::CFG_W-1:0]          cfg_data
);
	import cetc_pkg::*;

	state_t state_q;
	state_t state_d;
	op_t    op_q;

	// configuration registers
	logic [ITER_W-1:0] max_it_q;
	logic [RAD_W-1:0]  rad_q;

	logic              inv_q;
	logic [ITER_W-1:0] cnt_q;

	// datapath registers
	fx_t xr_q, xi_q, yr_q, yi_q;
	fx_t ar_q, ai_q, vr_q, vi_q;
	fx_t a2r_q, a2i_q;
	fx_t zr_q, zi_q;
	fx_t wr_q, wi_q, tr_q, ti_q;
	fx_t sr_q, si_q;
	fx_t acc_q;

	// shared multiplier
	logic mul_start;
	logic mul_done;
	fx_t  mul_a;
	fx_t  mul_b;
	fx_t  prod;

	// divide-by-three lanes
	logic div_start;
	logic div_done;
	fx_t  div_in  [DIV_LANES];
	fx_t  div_quo [DIV_LANES];

	// escape test
	fx_t              msq;
	logic [CMP_W-1:0] thr;
	logic             escape;
	logic             accept;

	assign accept    = start && (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	cetc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	always_comb begin
		div_in[0] = ar_q;
		div_in[1] = ai_q;
		div_in[2] = vr_q;
		div_in[3] = vi_q;
	end

	cetc_div3 u_div3 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.din    (div_in),
		.done   (div_done),
		.quo    (div_quo)
	);

	// operand routing for each step of the multiply sequence
	always_comb begin
		unique case (op_q)
			OP_ZRR:  begin mul_a = zr_q; mul_b = zr_q; end
			OP_ZII:  begin mul_a = zi_q; mul_b = zi_q; end
			OP_WRR:  begin mul_a = wr_q; mul_b = wr_q; end
			OP_WII:  begin mul_a = wi_q; mul_b = wi_q; end
			OP_WRI:  begin mul_a = wr_q; mul_b = wi_q; end
			OP_SRTR: begin mul_a = sr_q; mul_b = tr_q; end
			OP_SITI: begin mul_a = si_q; mul_b = ti_q; end
			OP_SRTI: begin mul_a = sr_q; mul_b = ti_q; end
			OP_SITR: begin mul_a = si_q; mul_b = tr_q; end
			default: begin mul_a = zr_q; mul_b = zr_q; end
		endcase
	end

	// |z|^2 from the held re^2 and the arriving im^2, against radius^2 scaled
	always_comb begin
		msq    = fx_add(acc_q, prod);
		thr    = CMP_W'({rad_q, {FRAC_BITS{1'b0}}});
		escape = CMP_W'($unsigned(msq)) >= thr;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) begin
				state_d = coord_invalid ? ST_DONE : ST_PREP1;
			end
			ST_PREP1: state_d = ST_PREP2;
			ST_PREP2: state_d = ST_DIV;
			ST_DIV:   state_d = ST_DIVW;
			ST_DIVW:  if (div_done) begin
				state_d = ST_ZINIT;
			end
			ST_ZINIT: state_d = ST_CHECK;
			ST_CHECK: state_d = (cnt_q >= max_it_q) ? ST_DONE : ST_MUL;
			ST_MUL:   state_d = ST_MULW;
			ST_MULW:  if (mul_done) begin
				priority if (op_q == OP_ZII && escape) begin
					state_d = ST_DONE;
				end else if (op_q == OP_SITR) begin
					state_d = ST_UPD;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_UPD:   state_d = ST_CHECK;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy      = (state_q != ST_IDLE);
		done      = (state_q == ST_DONE);
		mul_start = (state_q == ST_MUL);
		div_start = (state_q == ST_DIV);
	end

	assign escape_count = inv_q ? '1 : {1'b0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_ZRR;
			inv_q    <= 1'b0;
			cnt_q    <= '0;
			max_it_q <= MAX_ITER_RST;
			rad_q    <= RADIUS_RST;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (reg_idx_t'(cfg_index))
					REG_MAX_ITER:  max_it_q <= cfg_data[ITER_W-1:0];
					REG_RADIUS_SQ: rad_q    <= cfg_data[RAD_W-1:0];
					default:       ;
				endcase
			end
			if (accept) begin
				inv_q <= coord_invalid;
			end
			if (state_q == ST_ZINIT) begin
				cnt_q <= '0;
			end
			if (state_q == ST_CHECK) begin
				op_q <= OP_ZRR;
			end
			if (state_q == ST_MULW && mul_done) begin
				if (op_q != OP_SITR) begin
					op_q <= op_t'(op_q + 4'd1);
				end
				// count the iteration once it is known not to escape
				if (op_q == OP_ZII && !escape) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (start) begin
				xr_q <= from_q428(x_re);
				xi_q <= from_q428(x_im);
				yr_q <= from_q428(y_re);
				yi_q <= from_q428(y_im);
			end
			// a numerator y - x, v numerator 2x then + y
			ST_PREP1: begin
				ar_q <= fx_sub(yr_q, xr_q);
				ai_q <= fx_sub(yi_q, xi_q);
				vr_q <= fx_add(xr_q, xr_q);
				vi_q <= fx_add(xi_q, xi_q);
			end
			ST_PREP2: begin
				vr_q <= fx_add(vr_q, yr_q);
				vi_q <= fx_add(vi_q, yi_q);
			end
			ST_DIVW: if (div_done) begin
				ar_q <= div_quo[0];
				ai_q <= div_quo[1];
				vr_q <= div_quo[2];
				vi_q <= div_quo[3];
			end
			// orbit starts at -a, 2a kept for the z + 2a factor
			ST_ZINIT: begin
				zr_q  <= -ar_q;
				zi_q  <= -ai_q;
				a2r_q <= fx_add(ar_q, ar_q);
				a2i_q <= fx_add(ai_q, ai_q);
			end
			ST_MULW: if (mul_done) begin
				unique case (op_q)
					OP_ZRR:  acc_q <= prod;
					OP_ZII:  begin
						wr_q <= fx_sub(zr_q, ar_q);
						wi_q <= fx_sub(zi_q, ai_q);
						tr_q <= fx_add(zr_q, a2r_q);
						ti_q <= fx_add(zi_q, a2i_q);
					end
					OP_WRR:  acc_q <= prod;
					OP_WII:  sr_q  <= fx_sub(acc_q, prod);
					// cross terms of a square are equal
					OP_WRI:  si_q  <= fx_add(prod, prod);
					OP_SRTR: acc_q <= prod;
					OP_SITI: wr_q  <= fx_sub(acc_q, prod);
					OP_SRTI: acc_q <= prod;
					OP_SITR: wi_q  <= fx_add(acc_q, prod);
					default: ;
				endcase
			end
			ST_UPD: begin
				zr_q <= fx_add(wr_q, vr_q);
				zi_q <= fx_add(wi_q, vi_q);
			end
			default: ;
		endcase
	end

endmodule

/* hdl/cetc_checker.sv */
module cetc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [cetc_pkg::CNT_W-1:0] escape_count
);
	import cetc_pkg::*;

	`include "assert_macros.svh"

	// a result only appears while a request is in flight
	`CHK_SAME(a_done_busy, done, busy, "result strobe while not busy")
	// a taken request makes the block busy
	`CHK_NEXT(a_take_busy, start && !busy, busy, "request taken but block not busy")
	// one result per request, then the block is free
	`CHK_NEXT(a_done_free, done, !busy && !done, "block not free after result")
	// busy only drops right after a result
	`CHK_SAME(a_busy_fall, $fell(busy), $past(done), "busy dropped without a result")
	// a count is -1 or not negative
	`CHK_SAME(a_count_rng, done && escape_count[CNT_W-1], escape_count == '1,
		"negative count other than -1")

endmodule

bind cubic_escape_time_counter cetc_checker u_cetc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.escape_count (escape_count)
);
